/* rtl/superblock_record_checker_macros.svh */
// assertion macros for the superblock record checker
`ifndef SUPERBLOCK_RECORD_CHECKER_MACROS_SVH
`define SUPERBLOCK_RECORD_CHECKER_MACROS_SVH

// same-cycle implication, checked out of reset
`define SBRC_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define SBRC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/sbrc_pkg.sv */
// shared types, constants and the crc function of the superblock record checker
package sbrc_pkg;

  localparam int unsigned REC_LEN = 72;
  localparam int unsigned POS_W   = $clog2(REC_LEN);
  localparam logic [POS_W-1:0] REC_LAST = POS_W'(REC_LEN - 1);

  // byte offsets of the record fields
  localparam logic [POS_W-1:0] OFS_VERSION  = POS_W'(8);
  localparam logic [POS_W-1:0] OFS_CHECKSUM = POS_W'(12);
  localparam logic [POS_W-1:0] OFS_TOTAL    = POS_W'(16);
  localparam logic [POS_W-1:0] OFS_PRIMARY  = POS_W'(24);
  localparam logic [POS_W-1:0] OFS_BACKUP   = POS_W'(32);
  localparam logic [POS_W-1:0] OFS_NAME_LIM = POS_W'(40);
  localparam logic [POS_W-1:0] OFS_FILE_SEC = POS_W'(44);
  localparam logic [POS_W-1:0] OFS_FILE_CNT = POS_W'(48);
  localparam logic [POS_W-1:0] OFS_SEC_SIZE = POS_W'(52);
  localparam logic [POS_W-1:0] OFS_IDENT    = POS_W'(56);

  localparam logic [63:0] REC_MAGIC       = 64'h5346_4C49_4E55_584F;
  localparam logic [31:0] REC_VERSION     = 32'd1;
  localparam logic [31:0] REC_SECTOR_SIZE = 32'd512;

  localparam int unsigned CFG_W     = 48;
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_W-1:0] MIN_DEVICE_SECTORS = CFG_W'(3);
  localparam logic [CFG_W-1:0] COPY_SECTORS       = CFG_W'(2);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_TOTAL = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_EXP_PRIMARY  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_EXP_BACKUP   = CFG_IDX_W'(2);

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_SEED = 32'hFFFF_FFFF;

  // check status codes
  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_FORMAT = 2'd1;
  localparam logic [1:0] STATUS_CRC    = 2'd2;

  typedef struct packed {
    logic [1:0]  check_status;
    logic [31:0] sectors_per_file;
    logic [31:0] number_of_files;
    logic [31:0] name_length_limit;
    logic [31:0] computed_crc;
  } result_t;

  // reflected crc-32, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] data);
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

/* rtl/sbrc_ifs.sv */
// valid/ready channel interfaces of the superblock record checker
interface sbrc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;

  modport source(output valid, output data_byte, output first_byte, input ready);
  modport sink(input valid, input data_byte, input first_byte, output ready);
endinterface

interface sbrc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  check_status;
  logic [31:0] sectors_per_file;
  logic [31:0] number_of_files;
  logic [31:0] name_length_limit;
  logic [31:0] computed_crc;

  modport source(output valid, output check_status, output sectors_per_file,
                 output number_of_files, output name_length_limit,
                 output computed_crc, input ready);
  modport sink(input valid, input check_status, input sectors_per_file,
               input number_of_files, input name_length_limit,
               input computed_crc, output ready);
endinterface

interface sbrc_cfg_if;
  import sbrc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [CFG_W-1:0]     wdata;

  modport source(output valid, output reg_index, output wdata, input ready);
  modport sink(input valid, input reg_index, input wdata, output ready);
endinterface

/* rtl/superblock_record_checker.sv */
// superblock record checker: byte-serial capture, crc-32 and format check of a 72-byte record
// in_bus carries one record byte per transaction, with first_byte marking byte 0 of a
// record; a marked byte restarts capture and the crc wherever the record stood.
// After the 72nd byte one result goes out on out_bus: status (ok, bad format or
// geometry, checksum mismatch), file sectors, file count, name limit and the crc.
// cfg_bus writes the device sector count and the expected primary and backup
// sectors; it is always ready and a change counts at the next record end.
// Throughput is one byte per cycle while the skid register is empty: the crc byte
// step and the field capture sit between the state registers and the result register,
// and the file size times count product is registered from the captured fields well
// before the last byte. A free output register is loaded as the last byte is taken.
// A stalled receiver leaves the result in the output register and one more in a
// skid register; in_bus.ready is low only while that skid register is full.
// Synchronous reset (rst_n low) clears the byte position, seeds the crc, empties
// both result registers and loads the register defaults 0, 0 and 1.
`include "superblock_record_checker_macros.svh"

module superblock_record_checker (
  input  logic              clk,
  input  logic              rst_n,
  sbrc_in_if.sink           in_bus,
  sbrc_out_if.source        out_bus,
  sbrc_cfg_if.sink          cfg_bus
);
  import sbrc_pkg::*;

  // configuration
  logic [CFG_W-1:0] dev_total_r;
  logic [CFG_W-1:0] exp_primary_r;
  logic [CFG_W-1:0] exp_backup_r;

  // record walk
  logic [POS_W-1:0] pos_r;
  logic [31:0]      crc_r;

  // captured fields
  logic [63:0] magic_r;
  logic [31:0] version_r;
  logic [31:0] checksum_r;
  logic [63:0] total_r;
  logic [63:0] primary_r;
  logic [63:0] backup_r;
  logic [31:0] name_lim_r;
  logic [31:0] file_sec_r;
  logic [31:0] file_cnt_r;
  logic [31:0] sec_size_r;
  logic [63:0] prod_r;

  // result registers
  logic    out_valid_r, out_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t out_r, out_nxt;
  result_t skid_r, skid_nxt;

  logic             in_acc;
  logic [POS_W-1:0] pos;
  logic [31:0]      crc_base;
  logic [7:0]       crc_data;
  logic [31:0]      crc_val;
  logic             rec_last;
  logic             produce;
  logic [CFG_W-1:0] usable;
  logic             bad_format;
  result_t          res;

  assign in_bus.ready  = !skid_valid_r;
  assign in_acc        = in_bus.valid && in_bus.ready;
  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_total_r   <= '0;
      exp_primary_r <= '0;
      exp_backup_r  <= CFG_W'(1);
    end else if (cfg_bus.valid) begin
      unique case (cfg_bus.reg_index)
        CFG_DEVICE_TOTAL: dev_total_r   <= cfg_bus.wdata;
        CFG_EXP_PRIMARY:  exp_primary_r <= cfg_bus.wdata;
        CFG_EXP_BACKUP:   exp_backup_r  <= cfg_bus.wdata;
        default: ;
      endcase
    end
  end

  assign pos      = in_bus.first_byte ? '0 : pos_r;
  assign crc_base = in_bus.first_byte ? CRC_SEED : crc_r;
  // stored checksum bytes enter the crc as zero
  assign crc_data = (pos >= OFS_CHECKSUM && pos < OFS_TOTAL) ? 8'd0 : in_bus.data_byte;
  assign crc_val  = crc_byte(crc_base, crc_data);
  assign rec_last = (pos == REC_LAST);
  assign produce  = in_acc && rec_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      crc_r <= CRC_SEED;
    end else if (in_acc) begin
      if (rec_last) begin
        pos_r <= '0;
        crc_r <= CRC_SEED;
      end else begin
        pos_r <= pos + POS_W'(1);
        crc_r <= crc_val;
      end
    end
  end

  // fields are aligned, so the low position bits select the byte lane
  always_ff @(posedge clk) begin
    if (in_acc) begin
      priority if (pos < OFS_VERSION)  magic_r[8*pos[2:0] +: 8]    <= in_bus.data_byte;
      else if (pos < OFS_CHECKSUM)     version_r[8*pos[1:0] +: 8]  <= in_bus.data_byte;
      else if (pos < OFS_TOTAL)        checksum_r[8*pos[1:0] +: 8] <= in_bus.data_byte;
      else if (pos < OFS_PRIMARY)      total_r[8*pos[2:0] +: 8]    <= in_bus.data_byte;
      else if (pos < OFS_BACKUP)       primary_r[8*pos[2:0] +: 8]  <= in_bus.data_byte;
      else if (pos < OFS_NAME_LIM)     backup_r[8*pos[2:0] +: 8]   <= in_bus.data_byte;
      else if (pos < OFS_FILE_SEC)     name_lim_r[8*pos[1:0] +: 8] <= in_bus.data_byte;
      else if (pos < OFS_FILE_CNT)     file_sec_r[8*pos[1:0] +: 8] <= in_bus.data_byte;
      else if (pos < OFS_SEC_SIZE)     file_cnt_r[8*pos[1:0] +: 8] <= in_bus.data_byte;
      else if (pos < OFS_IDENT)        sec_size_r[8*pos[1:0] +: 8] <= in_bus.data_byte;
      else ;
    end
  end

  // fields settle by byte 51, so the product is ready long before byte 71
  always_ff @(posedge clk) begin
    prod_r <= 64'(file_sec_r) * 64'(file_cnt_r);
  end

  assign usable = dev_total_r - COPY_SECTORS;

  always_comb begin
    bad_format = (dev_total_r < MIN_DEVICE_SECTORS)
              || (magic_r != REC_MAGIC)
              || (version_r != REC_VERSION)
              || (sec_size_r != REC_SECTOR_SIZE)
              || (total_r != 64'(dev_total_r))
              || (primary_r != 64'(exp_primary_r))
              || (backup_r != 64'(exp_backup_r))
              || (primary_r == backup_r)
              || (primary_r >= 64'(dev_total_r))
              || (backup_r >= 64'(dev_total_r))
              || (file_sec_r == 32'd0)
              || (file_cnt_r == 32'd0)
              || (CFG_W'(file_sec_r) > usable)
              || (prod_r != 64'(usable));
  end

  always_comb begin
    res.check_status      = bad_format ? STATUS_FORMAT
                          : (checksum_r != crc_val) ? STATUS_CRC : STATUS_OK;
    res.sectors_per_file  = file_sec_r;
    res.number_of_files   = file_cnt_r;
    res.name_length_limit = name_lim_r;
    res.computed_crc      = crc_val;
  end

  // output register with one skid entry behind it
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    if (!out_valid_r || out_bus.ready) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = produce;
        out_nxt       = res;
      end
    end else if (produce) begin
      skid_valid_nxt = 1'b1;
      skid_nxt       = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_bus.valid             = out_valid_r;
  assign out_bus.check_status      = out_r.check_status;
  assign out_bus.sectors_per_file  = out_r.sectors_per_file;
  assign out_bus.number_of_files   = out_r.number_of_files;
  assign out_bus.name_length_limit = out_r.name_length_limit;
  assign out_bus.computed_crc      = out_r.computed_crc;

  `SBRC_ASSERT_NOW(a_pos_in_record, 1'b1, pos_r <= REC_LAST, "byte position past record end")
  `SBRC_ASSERT_NOW(a_skid_behind_out, skid_valid_r, out_valid_r, "skid entry without output entry")
  `SBRC_ASSERT_NEXT(a_last_gives_result, in_acc && rec_last, out_valid_r && pos_r == '0,
                    "record end did not give a result")

endmodule

/* verif/tb_superblock_record_checker.sv */
// testbench for the superblock record checker: byte-serial records, self-checking verdicts
module tb_superblock_record_checker;
  import sbrc_pkg::*;

  localparam int unsigned LIMIT_CYCLES   = 300000;
  localparam int unsigned LONG_HOLD      = 600;
  localparam int unsigned RAND_PHASES    = 2;
  localparam int unsigned RECS_PER_PHASE = 3;
  localparam int unsigned SETTLE_CYCLES  = 3;
  localparam int unsigned END_CYCLES     = 10;
  localparam int unsigned MAX_PRINTED    = 40;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(3);
  localparam logic [CFG_W-1:0]     SECT_MAX  = '1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } stream_byte_t;

  typedef enum int {
    FLT_NONE, FLT_MAGIC, FLT_VERSION, FLT_SEC_SIZE, FLT_TOTAL, FLT_TOTAL_HIGH,
    FLT_PRIMARY, FLT_BACKUP, FLT_SAME_COPY, FLT_FILE_SEC_ZERO, FLT_FILE_CNT_ZERO,
    FLT_FILE_SEC_BIG, FLT_PRODUCT, FLT_CHECKSUM, FLT_NOISE
  } fault_e;

  typedef enum int {GEO_MIN, GEO_SMALL, GEO_LARGE, GEO_WIDE_FILE, GEO_MANY_FILES} geo_e;

  logic clk;
  logic rst_n;

  sbrc_in_if  in_bus ();
  sbrc_out_if out_bus ();
  sbrc_cfg_if cfg_bus ();

  superblock_record_checker i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // checker state mirrored in the testbench
  logic [CFG_W-1:0] dev_total;
  logic [CFG_W-1:0] want_primary;
  logic [CFG_W-1:0] want_backup;
  int unsigned      rec_pos;
  logic [31:0]      crc_acc;
  logic [63:0]      rec_magic, rec_total, rec_primary, rec_backup;
  logic [31:0]      rec_version, rec_chk, rec_name_lim, rec_fsec, rec_fcnt, rec_ssize;

  result_t      expected_verdicts [$];
  stream_byte_t byte_stream [$];
  stream_byte_t nxt_byte;

  // stimulus planning
  logic [7:0]       rec_img [REC_LEN];
  logic [31:0]      geo_fsec, geo_fcnt;
  logic [CFG_W-1:0] plan_total, plan_primary, plan_backup;
  bit               need_first;

  // idling controls
  int unsigned gap_max;
  int unsigned stall_pct;
  int unsigned hold_left;
  int unsigned burst_left;
  int unsigned gap_left;

  int unsigned error_count;
  int unsigned cycle_count;

  function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] d);
    logic [31:0] r;
    r = c;
    // bit-serial form of the reflected crc
    for (int k = 0; k < 8; k++) begin
      r = (r >> 1) ^ ({32{r[0] ^ d[k]}} & CRC_POLY);
    end
    return r;
  endfunction

  function automatic logic [63:0] rand_below(input logic [63:0] n);
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r % n;
  endfunction

  task automatic flag(input string msg);
    if (error_count < MAX_PRINTED) begin
      $display("ERROR @%0t: %s", $realtime, msg);
    end
    error_count++;
  endtask

  task automatic absorb_byte(input logic [7:0] b, input logic first);
    int unsigned p;
    logic [63:0] usable;
    logic        bad;
    result_t     verdict;
    if (first) begin
      rec_pos = 0;
      crc_acc = CRC_SEED;
    end
    p = rec_pos;
    if (p < OFS_VERSION) rec_magic[8*p +: 8] = b;
    else if (p < OFS_CHECKSUM) rec_version[8*(p-OFS_VERSION) +: 8] = b;
    else if (p < OFS_TOTAL) rec_chk[8*(p-OFS_CHECKSUM) +: 8] = b;
    else if (p < OFS_PRIMARY) rec_total[8*(p-OFS_TOTAL) +: 8] = b;
    else if (p < OFS_BACKUP) rec_primary[8*(p-OFS_PRIMARY) +: 8] = b;
    else if (p < OFS_NAME_LIM) rec_backup[8*(p-OFS_BACKUP) +: 8] = b;
    else if (p < OFS_FILE_SEC) rec_name_lim[8*(p-OFS_NAME_LIM) +: 8] = b;
    else if (p < OFS_FILE_CNT) rec_fsec[8*(p-OFS_FILE_SEC) +: 8] = b;
    else if (p < OFS_SEC_SIZE) rec_fcnt[8*(p-OFS_FILE_CNT) +: 8] = b;
    else if (p < OFS_IDENT) rec_ssize[8*(p-OFS_SEC_SIZE) +: 8] = b;
    // stored checksum bytes enter the crc as zero
    crc_acc = crc_step(crc_acc, (p >= OFS_CHECKSUM && p < OFS_TOTAL) ? 8'h00 : b);
    if (p != REC_LEN - 1) begin
      rec_pos = p + 1;
    end else begin
      usable = 64'(dev_total) - 64'(COPY_SECTORS);
      bad = (dev_total < MIN_DEVICE_SECTORS) || (rec_magic != REC_MAGIC) ||
            (rec_version != REC_VERSION) || (rec_ssize != REC_SECTOR_SIZE) ||
            (rec_total != 64'(dev_total)) ||
            (rec_primary != 64'(want_primary)) || (rec_backup != 64'(want_backup)) ||
            (rec_primary == rec_backup) ||
            (rec_primary >= 64'(dev_total)) || (rec_backup >= 64'(dev_total)) ||
            (rec_fsec == '0) || (rec_fcnt == '0) || (64'(rec_fsec) > usable) ||
            (64'(rec_fsec) * 64'(rec_fcnt) != usable);
      if (bad) verdict.check_status = STATUS_FORMAT;
      else if (rec_chk != crc_acc) verdict.check_status = STATUS_CRC;
      else verdict.check_status = STATUS_OK;
      verdict.sectors_per_file  = rec_fsec;
      verdict.number_of_files   = rec_fcnt;
      verdict.name_length_limit = rec_name_lim;
      verdict.computed_crc      = crc_acc;
      expected_verdicts.push_back(verdict);
      rec_pos = 0;
      crc_acc = CRC_SEED;
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_bus.valid     <= 1'b1;
    cfg_bus.reg_index <= idx;
    cfg_bus.wdata     <= val;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    case (idx)
      CFG_DEVICE_TOTAL: dev_total = val;
      CFG_EXP_PRIMARY:  want_primary = val;
      CFG_EXP_BACKUP:   want_backup = val;
      default: ;
    endcase
  endtask

  task automatic apply_plan();
    write_reg(CFG_DEVICE_TOTAL, plan_total);
    write_reg(CFG_EXP_PRIMARY, plan_primary);
    write_reg(CFG_EXP_BACKUP, plan_backup);
    if ($urandom_range(2, 0) == 0) write_reg(CFG_SPARE, CFG_W'({$urandom, $urandom}));
  endtask

  // file geometry that fills the device exactly, copies at distinct sectors
  task automatic plan_geometry(input geo_e kind);
    logic [63:0] tot;
    case (kind)
      GEO_MIN: begin
        geo_fsec = 32'd1;
        geo_fcnt = 32'd1;
      end
      GEO_SMALL: begin
        geo_fsec = $urandom_range(64, 1);
        geo_fcnt = $urandom_range(64, 1);
      end
      GEO_LARGE: begin
        geo_fsec = $urandom | 32'd1;
        geo_fcnt = $urandom_range(65535, 1);
      end
      GEO_WIDE_FILE: begin
        geo_fsec = '1;
        geo_fcnt = ($urandom_range(1, 0) == 0) ? 32'd65535 : $urandom_range(65535, 1);
      end
      default: begin
        geo_fsec = $urandom_range(3, 1);
        geo_fcnt = ($urandom_range(1, 0) == 0) ? 32'hFFFF_FFFF : ($urandom | 32'd1);
      end
    endcase
    tot = 64'(geo_fsec) * 64'(geo_fcnt) + 64'(COPY_SECTORS);
    plan_total   = tot[CFG_W-1:0];
    plan_primary = CFG_W'(rand_below(tot));
    plan_backup  = CFG_W'(rand_below(tot));
    if (plan_backup == plan_primary) plan_backup = CFG_W'((64'(plan_primary) + 64'd1) % tot);
  endtask

  task automatic put_field(input int ofs, input int n, input logic [63:0] v);
    for (int k = 0; k < n; k++) begin
      rec_img[ofs+k] = v[8*k +: 8];
    end
  endtask

  task automatic build_record(input fault_e flt);
    logic [31:0] seal;
    logic [31:0] name_lim;
    logic [31:0] ver;
    for (int k = 0; k < REC_LEN; k++) begin
      rec_img[k] = 8'($urandom);
    end
    if (flt != FLT_NOISE) begin
      case ($urandom_range(3, 0))
        0:       name_lim = '0;
        1:       name_lim = '1;
        default: name_lim = $urandom;
      endcase
      put_field(0, 8, REC_MAGIC);
      put_field(OFS_VERSION, 4, REC_VERSION);
      put_field(OFS_TOTAL, 8, dev_total);
      put_field(OFS_PRIMARY, 8, want_primary);
      put_field(OFS_BACKUP, 8, want_backup);
      put_field(OFS_NAME_LIM, 4, name_lim);
      put_field(OFS_FILE_SEC, 4, geo_fsec);
      put_field(OFS_FILE_CNT, 4, geo_fcnt);
      put_field(OFS_SEC_SIZE, 4, REC_SECTOR_SIZE);
      case (flt)
        FLT_MAGIC: rec_img[$urandom_range(7, 0)] ^= 8'(1 << $urandom_range(7, 0));
        FLT_VERSION: begin
          ver = $urandom_range(1, 0) ? 32'd0 : $urandom;
          if (ver == REC_VERSION) ver = 32'd2;
          put_field(OFS_VERSION, 4, ver);
        end
        FLT_SEC_SIZE: put_field(OFS_SEC_SIZE, 4, REC_SECTOR_SIZE ^ (32'd1 << $urandom_range(31, 0)));
        FLT_TOTAL: put_field(OFS_TOTAL, 8, 64'(dev_total) ^ (64'd1 << $urandom_range(47, 0)));
        // bits above the register width must still take part in the compare
        FLT_TOTAL_HIGH: rec_img[OFS_TOTAL + $urandom_range(7, 6)] = 8'($urandom_range(255, 1));
        FLT_PRIMARY: rec_img[OFS_PRIMARY + $urandom_range(7, 0)] ^= 8'(1 << $urandom_range(7, 0));
        FLT_BACKUP: rec_img[OFS_BACKUP + $urandom_range(7, 0)] ^= 8'(1 << $urandom_range(7, 0));
        FLT_SAME_COPY: put_field(OFS_BACKUP, 8, want_primary);
        FLT_FILE_SEC_ZERO: put_field(OFS_FILE_SEC, 4, 32'd0);
        FLT_FILE_CNT_ZERO: put_field(OFS_FILE_CNT, 4, 32'd0);
        FLT_FILE_SEC_BIG: put_field(OFS_FILE_SEC, 4, 32'(dev_total - CFG_W'(1)));
        FLT_PRODUCT: put_field(OFS_FILE_CNT, 4, geo_fcnt + 32'd1);
        default: ;
      endcase
    end
    if (flt != FLT_NOISE || $urandom_range(1, 0) == 1) begin
      seal = CRC_SEED;
      for (int k = 0; k < REC_LEN; k++) begin
        seal = crc_step(seal, (k >= OFS_CHECKSUM && k < OFS_TOTAL) ? 8'h00 : rec_img[k]);
      end
      put_field(OFS_CHECKSUM, 4, seal);
    end
    if (flt == FLT_CHECKSUM) begin
      rec_img[OFS_CHECKSUM + $urandom_range(3, 0)] ^= 8'($urandom_range(255, 1));
    end
  endtask

  task automatic fill_record(input logic [7:0] b);
    for (int k = 0; k < REC_LEN; k++) begin
      rec_img[k] = b;
    end
  endtask

  task automatic queue_record(input bit mark_first, input int len);
    stream_byte_t sb;
    for (int k = 0; k < len; k++) begin
      sb.data_byte  = rec_img[k];
      sb.first_byte = mark_first && (k == 0);
      byte_stream.push_back(sb);
    end
  endtask

  task automatic queue_noise(input int len);
    stream_byte_t sb;
    for (int k = 0; k < len; k++) begin
      sb.data_byte  = 8'($urandom);
      sb.first_byte = ($urandom_range(15, 0) == 0);
      byte_stream.push_back(sb);
    end
  endtask

  // idle point: nothing queued, nothing in flight, every verdict returned
  task automatic settle();
    do @(negedge clk);
    while (byte_stream.size() != 0 || in_bus.valid || expected_verdicts.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // record byte sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (in_bus.valid && in_bus.ready) absorb_byte(in_bus.data_byte, in_bus.first_byte);
      if (!in_bus.valid || in_bus.ready) begin
        if (gap_left != 0 || byte_stream.size() == 0) begin
          in_bus.valid <= 1'b0;
          if (gap_left != 0) gap_left--;
        end else begin
          nxt_byte = byte_stream.pop_front();
          in_bus.valid      <= 1'b1;
          in_bus.data_byte  <= nxt_byte.data_byte;
          in_bus.first_byte <= nxt_byte.first_byte;
          if (burst_left != 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(24, 1);
            gap_left   = (gap_max == 0) ? 0 : $urandom_range(gap_max, 1);
          end
        end
      end
    end
  end

  // result receiver backpressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_bus.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_bus.ready <= ($urandom_range(99, 0) >= stall_pct);
    end
  end

  // verdict compare
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (expected_verdicts.size() == 0) begin
        flag("result transaction with no verdict expected");
      end else begin
        want = expected_verdicts.pop_front();
        if (out_bus.check_status !== want.check_status)
          flag($sformatf("check_status got %0d want %0d", out_bus.check_status,
                         want.check_status));
        if (out_bus.sectors_per_file !== want.sectors_per_file)
          flag($sformatf("sectors_per_file got %h want %h", out_bus.sectors_per_file,
                         want.sectors_per_file));
        if (out_bus.number_of_files !== want.number_of_files)
          flag($sformatf("number_of_files got %h want %h", out_bus.number_of_files,
                         want.number_of_files));
        if (out_bus.name_length_limit !== want.name_length_limit)
          flag($sformatf("name_length_limit got %h want %h", out_bus.name_length_limit,
                         want.name_length_limit));
        if (out_bus.computed_crc !== want.computed_crc)
          flag($sformatf("computed_crc got %h want %h", out_bus.computed_crc,
                         want.computed_crc));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned roll;
    fault_e      flt;
    rst_n             = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.data_byte  = '0;
    in_bus.first_byte = 1'b0;
    out_bus.ready     = 1'b0;
    cfg_bus.valid     = 1'b0;
    cfg_bus.reg_index = '0;
    cfg_bus.wdata     = '0;
    dev_total     = '0;
    want_primary  = '0;
    want_backup   = CFG_W'(1);
    rec_pos       = 0;
    crc_acc       = CRC_SEED;
    rec_magic     = '0;
    rec_total     = '0;
    rec_primary   = '0;
    rec_backup    = '0;
    rec_version   = '0;
    rec_chk       = '0;
    rec_name_lim  = '0;
    rec_fsec      = '0;
    rec_fcnt      = '0;
    rec_ssize     = '0;
    geo_fsec      = 32'd1;
    geo_fcnt      = 32'd1;
    gap_max       = 0;
    stall_pct     = 0;
    hold_left     = 0;
    error_count   = 0;
    cycle_count   = 0;
    need_first    = 1'b1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // register defaults: device too small, so any record is a format failure
    @(negedge clk);
    build_record(FLT_NONE);
    queue_record(1'b0, REC_LEN);
    settle();

    // smallest device that can hold a layout, each check in turn
    plan_geometry(GEO_MIN);
    apply_plan();
    gap_max   = 3;
    stall_pct = 30;
    @(negedge clk);
    for (int f = FLT_MAGIC; f <= FLT_NOISE; f++) begin
      build_record(fault_e'(f));
      queue_record(1'b1, REC_LEN);
    end
    // restart in the middle of a record
    build_record(FLT_NONE);
    queue_record(1'b1, 30);
    build_record(FLT_NONE);
    queue_record(1'b1, REC_LEN);
    // unmarked start right after a record end
    fill_record(8'h00);
    queue_record(1'b0, REC_LEN);
    settle();

    // all registers at their maximum
    plan_total   = SECT_MAX;
    plan_primary = SECT_MAX;
    plan_backup  = SECT_MAX;
    apply_plan();
    write_reg(CFG_SPARE, SECT_MAX);
    @(negedge clk);
    build_record(FLT_NONE);
    queue_record(1'b1, REC_LEN);
    settle();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      plan_geometry(geo_e'($urandom_range(GEO_MANY_FILES, GEO_MIN)));
      roll = $urandom_range(99, 0);
      if (roll < 15) plan_backup = plan_primary;
      else if (roll < 25) plan_primary = plan_total + CFG_W'($urandom_range(5, 0));
      else if (roll < 35) plan_total = CFG_W'($urandom_range(2, 0));
      apply_plan();
      case ($urandom_range(2, 0))
        0:       gap_max = 0;
        1:       gap_max = 2;
        default: gap_max = 8;
      endcase
      case ($urandom_range(2, 0))
        0:       stall_pct = 0;
        1:       stall_pct = 25;
        default: stall_pct = 60;
      endcase
      @(negedge clk);
      if (ph == 1) begin
        // receiver holds off while the sender streams back to back
        gap_max   = 0;
        stall_pct = 0;
        hold_left = LONG_HOLD;
      end
      need_first = 1'b1;
      for (int r = 0; r < RECS_PER_PHASE; r++) begin
        roll = $urandom_range(99, 0);
        if (roll >= 92) begin
          queue_noise($urandom_range(40, 1));
          need_first = 1'b1;
        end else if (roll >= 84) begin
          build_record(FLT_NONE);
          queue_record($urandom_range(1, 0), $urandom_range(REC_LEN - 1, 1));
          need_first = 1'b1;
        end
        if (roll >= 55 && roll < 84) flt = fault_e'($urandom_range(FLT_NOISE, FLT_MAGIC));
        else flt = FLT_NONE;
        build_record(flt);
        queue_record(need_first || ($urandom_range(3, 0) != 0), REC_LEN);
        need_first = 1'b0;
      end
      settle();
    end

    repeat (END_CYCLES) @(negedge clk);
    if (expected_verdicts.size() != 0) flag("verdicts left over at end of run");
    if (error_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/sbrc_pkg.sv
rtl/sbrc_ifs.sv
rtl/superblock_record_checker.sv
verif/tb_superblock_record_checker.sv
